// ===== sv/dts_pkg.sv =====
// Shared types and codes for the delta timer task scheduler.
`default_nettype none
package dts_pkg;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_TICK     = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_DELETE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_TICKED   = 3'd2,
    ST_RUN      = 3'd3,
    ST_NONE     = 3'd4,
    ST_DELETED  = 3'd5,
    ST_REFUSED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FINISH
  } fsm_t;

  typedef struct packed {
    logic        used;
    logic        armed;
    logic [31:0] ticks;
    logic [31:0] period;
    logic [7:0]  pending;
    logic [31:0] handle;
  } slot_rec_t;

  typedef struct packed {
    op_t         op;
    logic        claim_ok;
    logic        del_hit;
    logic [31:0] handle;
    logic [31:0] delay;
    logic [31:0] period;
  } head_ctl_t;

endpackage
`default_nettype wire

// ===== sv/delta_timer_task_scheduler.sv =====
// Top level: task-timer table as a rotating ring of slot cells with one head cell.
// Each request rotates the ring once: busy through the scan and finish states after acceptance.
// The final result strobe is registered from the finish state.
// Dispatch results come at most one per cycle; each is held until the next pending slot
// passes the head or the scan ends. Results cannot be stalled.
// Synchronous reset clears every slot cell directly; no clearing pass.
`default_nettype none
module delta_timer_task_scheduler #(
  parameter int POOL_SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  operation,
  input  wire  [31:0] task_handle,
  input  wire  [31:0] first_delay,
  input  wire  [31:0] repeat_period,
  input  wire  [7:0]  target_slot,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [5:0]  slot_id,
  output logic [31:0] run_handle,
  output logic [6:0]  fired_count,
  output logic        last
);
  import dts_pkg::*;

  localparam int IDXW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(POOL_SLOTS - 1);

  fsm_t fsm, fsm_next;
  logic accept;
  logic scan_end;

  op_t             op_q;
  logic [31:0]     handle_q;
  logic [31:0]     delay_q;
  logic [31:0]     period_q;
  logic [7:0]      target_q;
  logic [IDXW-1:0] idx;
  logic            found;
  logic [IDXW-1:0] add_slot;
  logic [6:0]      fired;
  logic            held_v;
  logic [IDXW-1:0] held_slot;
  logic [31:0]     held_handle;
  logic            del_done;

  slot_rec_t cell_q [POOL_SLOTS];
  slot_rec_t head_nxt;
  head_ctl_t ctl;
  logic      hit;
  logic      shift;

  assign accept   = start && !busy;
  assign scan_end = (idx == LAST_IDX);
  assign shift    = (fsm == FSM_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= FSM_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  always_comb begin
    fsm_next = fsm;
    busy     = 1'b1;
    unique case (fsm)
      FSM_IDLE: begin
        busy = 1'b0;
        if (start) begin
          fsm_next = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (scan_end) begin
          fsm_next = FSM_FINISH;
        end
      end
      FSM_FINISH: fsm_next = FSM_IDLE;
      default:    fsm_next = FSM_IDLE;
    endcase
  end

  assign ctl.op       = op_q;
  assign ctl.claim_ok = !found;
  assign ctl.del_hit  = (target_q == 8'(idx));
  assign ctl.handle   = handle_q;
  assign ctl.delay    = delay_q;
  assign ctl.period   = period_q;

  dts_head u_head (
    .ctl (ctl),
    .cur (cell_q[0]),
    .nxt (head_nxt),
    .hit (hit)
  );

  for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
    if (i == POOL_SLOTS - 1) begin : g_tail
      dts_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (head_nxt),
        .q     (cell_q[i])
      );
    end else begin : g_mid
      dts_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (cell_q[i+1]),
        .q     (cell_q[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (fsm == FSM_FINISH) ||
                (shift && hit && (op_q == OP_DISPATCH) && held_v);
    end
    if (accept) begin
      op_q     <= op_t'(operation);
      handle_q <= task_handle;
      delay_q  <= first_delay;
      period_q <= repeat_period;
      target_q <= target_slot;
      idx      <= '0;
      found    <= 1'b0;
      fired    <= 7'd0;
      held_v   <= 1'b0;
      del_done <= 1'b0;
    end
    if (fsm == FSM_SCAN) begin
      idx <= scan_end ? '0 : idx + 1'b1;
      if (hit) begin
        unique case (op_q)
          OP_ADD: begin
            found    <= 1'b1;
            add_slot <= idx;
          end
          OP_TICK: fired <= fired + 7'd1;
          OP_DISPATCH: begin
            if (held_v) begin
              status      <= ST_RUN;
              slot_id     <= 6'(held_slot);
              run_handle  <= held_handle;
              fired_count <= 7'd0;
              last        <= 1'b0;
            end
            held_v      <= 1'b1;
            held_slot   <= idx;
            held_handle <= cell_q[0].handle;
          end
          OP_DELETE: del_done <= 1'b1;
          default: ;
        endcase
      end
    end
    if (fsm == FSM_FINISH) begin
      last <= 1'b1;
      unique case (op_q)
        OP_ADD: begin
          status      <= found ? ST_ADDED : ST_FULL;
          slot_id     <= found ? 6'(add_slot) : 6'd0;
          run_handle  <= 32'd0;
          fired_count <= 7'd0;
        end
        OP_TICK: begin
          status      <= ST_TICKED;
          slot_id     <= 6'd0;
          run_handle  <= 32'd0;
          fired_count <= fired;
        end
        OP_DISPATCH: begin
          status      <= held_v ? ST_RUN : ST_NONE;
          slot_id     <= held_v ? 6'(held_slot) : 6'd0;
          run_handle  <= held_v ? held_handle : 32'd0;
          fired_count <= 7'd0;
        end
        OP_DELETE: begin
          status      <= del_done ? ST_DELETED : ST_REFUSED;
          slot_id     <= del_done ? target_q[5:0] : 6'd0;
          run_handle  <= 32'd0;
          fired_count <= 7'd0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/dts_cell.sv =====
// One slot cell of the rotating slot ring.
`default_nettype none
module dts_cell (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     shift,
  input  wire dts_pkg::slot_rec_t d,
  output dts_pkg::slot_rec_t      q
);
  import dts_pkg::*;

  slot_rec_t rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (shift) begin
      rec <= d;
    end
  end

  assign q = rec;
endmodule
`default_nettype wire

// ===== sv/dts_head.sv =====
// Head cell logic: applies the current request to the slot passing the ring head.
`default_nettype none
module dts_head (
  input  wire dts_pkg::head_ctl_t ctl,
  input  wire dts_pkg::slot_rec_t cur,
  output dts_pkg::slot_rec_t      nxt,
  output logic                    hit
);
  import dts_pkg::*;

  always_comb begin
    nxt = cur;
    hit = 1'b0;
    unique case (ctl.op)
      OP_ADD: begin
        if (ctl.claim_ok && !cur.used) begin
          hit         = 1'b1;
          nxt.used    = 1'b1;
          nxt.armed   = 1'b1;
          nxt.ticks   = ctl.delay;
          nxt.period  = ctl.period;
          nxt.pending = 8'd0;
          nxt.handle  = ctl.handle;
        end
      end
      OP_TICK: begin
        if (cur.armed) begin
          if (cur.ticks == 32'd0) begin
            hit = 1'b1;
            if (cur.pending != 8'hFF) begin
              nxt.pending = cur.pending + 8'd1;
            end
            if (cur.period != 32'd0) begin
              nxt.ticks = cur.period - 32'd1;
            end else begin
              nxt.armed = 1'b0;
            end
          end else begin
            nxt.ticks = cur.ticks - 32'd1;
          end
        end
      end
      OP_DISPATCH: begin
        if (cur.pending != 8'd0) begin
          hit         = 1'b1;
          nxt.pending = cur.pending - 8'd1;
          if (cur.period == 32'd0) begin
            nxt = '0;
          end
        end
      end
      OP_DELETE: begin
        if (ctl.del_hit && cur.used) begin
          hit = 1'b1;
          nxt = '0;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== tb/dts_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the task scheduler: predicts each request's responses and compares them.
module dts_result_checker #(
  parameter int POOL_SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire         busy,
  input  wire  [1:0]  operation,
  input  wire  [31:0] task_handle,
  input  wire  [31:0] first_delay,
  input  wire  [31:0] repeat_period,
  input  wire  [7:0]  target_slot,
  input  wire         strobe,
  input  wire  [2:0]  status,
  input  wire  [5:0]  slot_id,
  input  wire  [31:0] run_handle,
  input  wire  [6:0]  fired_count,
  input  wire         last,
  output int          fail_count,
  output int          outstanding
);
  import dts_pkg::*;

  typedef struct {
    status_t     status;
    logic [5:0]  slot;
    logic [31:0] handle;
    logic [6:0]  fired;
    logic        last;
  } result_rec_t;

  logic        slot_used    [POOL_SLOTS];
  logic        slot_armed   [POOL_SLOTS];
  logic [31:0] slot_ticks   [POOL_SLOTS];
  logic [31:0] slot_period  [POOL_SLOTS];
  logic [7:0]  slot_pending [POOL_SLOTS];
  logic [31:0] slot_handle  [POOL_SLOTS];

  result_rec_t due_results[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic clear_slot(int i);
    slot_used[i]    = 1'b0;
    slot_armed[i]   = 1'b0;
    slot_ticks[i]   = '0;
    slot_period[i]  = '0;
    slot_pending[i] = '0;
    slot_handle[i]  = '0;
  endtask

  task automatic push_result(status_t s, int slot, logic [31:0] h, int fired, logic fin);
    result_rec_t r;
    r.status = s;
    r.slot   = slot[5:0];
    r.handle = h;
    r.fired  = fired[6:0];
    r.last   = fin;
    due_results.push_back(r);
  endtask

  task automatic schedule_request(op_t op, logic [31:0] hnd, logic [31:0] dly,
                                  logic [31:0] per, logic [7:0] tgt);
    int free_slot;
    int fired;
    int ready;
    int k;
    case (op)
      OP_ADD: begin
        free_slot = -1;
        for (int i = 0; i < POOL_SLOTS; i++)
          if (!slot_used[i] && free_slot < 0) free_slot = i;
        if (free_slot >= 0) begin
          slot_used[free_slot]    = 1'b1;
          slot_armed[free_slot]   = 1'b1;
          slot_ticks[free_slot]   = dly;
          slot_period[free_slot]  = per;
          slot_pending[free_slot] = '0;
          slot_handle[free_slot]  = hnd;
          push_result(ST_ADDED, free_slot, '0, 0, 1'b1);
        end else begin
          push_result(ST_FULL, 0, '0, 0, 1'b1);
        end
      end
      OP_TICK: begin
        fired = 0;
        for (int i = 0; i < POOL_SLOTS; i++) begin
          if (slot_armed[i]) begin
            if (slot_ticks[i] == 0) begin
              fired++;
              if (slot_pending[i] != 8'hFF) slot_pending[i]++;
              if (slot_period[i] != 0) slot_ticks[i] = slot_period[i] - 1;
              else slot_armed[i] = 1'b0;
            end else begin
              slot_ticks[i]--;
            end
          end
        end
        push_result(ST_TICKED, 0, '0, fired, 1'b1);
      end
      OP_DISPATCH: begin
        ready = 0;
        for (int i = 0; i < POOL_SLOTS; i++)
          if (slot_pending[i] != 0) ready++;
        if (ready == 0) begin
          push_result(ST_NONE, 0, '0, 0, 1'b1);
        end else begin
          k = 0;
          for (int i = 0; i < POOL_SLOTS; i++) begin
            if (slot_pending[i] != 0) begin
              k++;
              push_result(ST_RUN, i, slot_handle[i], 0, k == ready);
              slot_pending[i]--;
              if (slot_period[i] == 0) clear_slot(i);
            end
          end
        end
      end
      default: begin
        if (int'(tgt) >= POOL_SLOTS || !slot_used[int'(tgt)]) begin
          push_result(ST_REFUSED, 0, '0, 0, 1'b1);
        end else begin
          clear_slot(int'(tgt));
          push_result(ST_DELETED, int'(tgt), '0, 0, 1'b1);
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_rec_t want;
    if (rst) begin
      for (int i = 0; i < POOL_SLOTS; i++) clear_slot(i);
    end else begin
      if (strobe) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                   $time, status, slot_id);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("slot_id", 32'(want.slot), 32'(slot_id));
          check_field("run_handle", want.handle, run_handle);
          check_field("fired_count", 32'(want.fired), 32'(fired_count));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      if (start && !busy)
        schedule_request(op_t'(operation), task_handle, first_delay, repeat_period,
                         target_slot);
    end
    outstanding = due_results.size();
  end

endmodule

// ===== tb/tb_delta_timer_task_scheduler.sv =====
`timescale 1ns / 1ps
// Testbench top for the task scheduler: request stimulus, idle phases, watchdog and verdict.
module tb_delta_timer_task_scheduler;
  import dts_pkg::*;

  localparam int POOL_SLOTS  = 16;
  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [31:0] task_handle;
  logic [31:0] first_delay;
  logic [31:0] repeat_period;
  logic [7:0]  target_slot;
  logic        strobe;
  logic [2:0]  status;
  logic [5:0]  slot_id;
  logic [31:0] run_handle;
  logic [6:0]  fired_count;
  logic        last;

  int fail_count;
  int outstanding;
  int idle_pct = 0;
  int quiet = 0;
  int idle_plan[4] = '{0, 48, 0, 14};

  delta_timer_task_scheduler #(
    .POOL_SLOTS(POOL_SLOTS)
  ) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .task_handle(task_handle), .first_delay(first_delay),
    .repeat_period(repeat_period), .target_slot(target_slot),
    .strobe(strobe), .status(status), .slot_id(slot_id), .run_handle(run_handle),
    .fired_count(fired_count), .last(last)
  );

  dts_result_checker #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .task_handle(task_handle), .first_delay(first_delay),
    .repeat_period(repeat_period), .target_slot(target_slot),
    .strobe(strobe), .status(status), .slot_id(slot_id), .run_handle(run_handle),
    .fired_count(fired_count), .last(last),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one request; start stays high on return so back-to-back requests need no gap
  task automatic issue(op_t op, logic [31:0] hnd, logic [31:0] dly, logic [31:0] per,
                       logic [7:0] tgt);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2 * POOL_SLOTS + 4)) @(posedge clk);
    end
    start         <= 1'b1;
    operation     <= op;
    task_handle   <= hnd;
    first_delay   <= dly;
    repeat_period <= per;
    target_slot   <= tgt;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    int          pick;
    op_t         op;
    logic [31:0] dly;
    logic [31:0] per;
    logic [7:0]  tgt;

    rst           <= 1'b1;
    start         <= 1'b0;
    operation     <= OP_ADD;
    task_handle   <= '0;
    first_delay   <= '0;
    repeat_period <= '0;
    target_slot   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed
    issue(OP_DISPATCH, 32'h0, 32'h0, 32'h0, 8'd0);
    issue(OP_TICK, 32'h0, 32'h0, 32'h0, 8'd0);
    issue(OP_DELETE, 32'h0, 32'h0, 32'h0, 8'd0);
    issue(OP_DELETE, 32'h0, 32'h0, 32'h0, 8'd255);
    issue(OP_DELETE, 32'h0, 32'h0, 32'h0, 8'(POOL_SLOTS));
    issue(OP_ADD, 32'h0, 32'h0, 32'h0, 8'd0);
    issue(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    issue(OP_ADD, 32'h1234_5678, 32'd1, 32'd2, 8'd0);
    issue(OP_ADD, 32'hA5A5_A5A5, 32'd0, 32'd1, 8'd0);
    issue(OP_TICK, 32'h0, 32'h0, 32'h0, 8'd0);
    issue(OP_TICK, 32'h0, 32'h0, 32'h0, 8'd0);
    issue(OP_DISPATCH, 32'h0, 32'h0, 32'h0, 8'd0);
    issue(OP_DISPATCH, 32'h0, 32'h0, 32'h0, 8'd0);
    issue(OP_DELETE, 32'h0, 32'h0, 32'h0, 8'(POOL_SLOTS - 1));
    issue(OP_DELETE, 32'h0, 32'h0, 32'h0, 8'd1);
    issue(OP_DELETE, 32'h0, 32'h0, 32'h0, 8'd3);
    issue(OP_ADD, 32'h5A5A_5A5A, 32'd3, 32'd0, 8'd0);

    // random, in idle phases
    foreach (idle_plan[p]) begin
      wait_drain();
      idle_pct = idle_plan[p];
      repeat (40) begin
        pick = $urandom_range(99);
        if (pick < 30) op = OP_ADD;
        else if (pick < 65) op = OP_TICK;
        else if (pick < 85) op = OP_DISPATCH;
        else op = OP_DELETE;
        pick = $urandom_range(9);
        if (pick < 6) dly = $urandom_range(0, 5);
        else if (pick < 8) dly = $urandom_range(0, 40);
        else dly = $urandom;
        pick = $urandom_range(9);
        if (pick < 3) per = '0;
        else if (pick < 7) per = $urandom_range(1, 6);
        else if (pick < 9) per = $urandom_range(7, 50);
        else per = $urandom;
        tgt = ($urandom_range(9) < 8) ? 8'($urandom_range(0, POOL_SLOTS - 1))
                                      : 8'($urandom_range(0, 255));
        issue(op, $urandom, dly, per, tgt);
      end
    end

    // fill the pool, saturate pending runs, full dispatch, then empty the pool
    wait_drain();
    idle_pct = 14;
    for (int i = 0; i <= POOL_SLOTS; i++) issue(OP_ADD, $urandom, 32'd0, 32'd1, 8'd0);
    repeat (258) issue(OP_TICK, $urandom, $urandom, $urandom, 8'($urandom));
    repeat (2) issue(OP_DISPATCH, $urandom, $urandom, $urandom, 8'($urandom));
    for (int i = 0; i < POOL_SLOTS; i++) issue(OP_DELETE, $urandom, $urandom, $urandom, 8'(i));

    wait_drain();
    repeat (2 * POOL_SLOTS) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dts_pkg.sv
sv/dts_cell.sv
sv/dts_head.sv
sv/delta_timer_task_scheduler.sv
tb/dts_result_checker.sv
tb/tb_delta_timer_task_scheduler.sv
